>>> sv/tcgq_pkg.sv
// Package for the two-contact grasp quality unit: payload types and shared constants.
package tcgq_pkg;

    localparam int FIELD_W = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] first_point_x;
        logic signed [FIELD_W-1:0] first_point_y;
        logic signed [FIELD_W-1:0] first_point_z;
        logic signed [FIELD_W-1:0] first_normal_x;
        logic signed [FIELD_W-1:0] first_normal_y;
        logic signed [FIELD_W-1:0] first_normal_z;
        logic signed [FIELD_W-1:0] second_point_x;
        logic signed [FIELD_W-1:0] second_point_y;
        logic signed [FIELD_W-1:0] second_point_z;
        logic signed [FIELD_W-1:0] second_normal_x;
        logic signed [FIELD_W-1:0] second_normal_y;
        logic signed [FIELD_W-1:0] second_normal_z;
    } grasp_in_t;

    typedef struct packed {
        logic signed [31:0] antipodal_score;
        logic               force_closure;
        logic               degenerate;
    } grasp_out_t;

    localparam int MU_W = 24;
    localparam int ONE30 = 1 << 30;

endpackage

>>> sv/tcgq_unitize.sv
// Pipelined vector unitizer: block scale, square sum, square root, three divides.
module tcgq_unitize
    import tcgq_pkg::*;
#(
    parameter int IN_W = 50
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic signed [IN_W-1:0] vx,
    input  logic signed [IN_W-1:0] vy,
    input  logic signed [IN_W-1:0] vz,
    output logic signed [31:0]     ux,
    output logic signed [31:0]     uy,
    output logic signed [31:0]     uz
);
    // Stage A: magnitude and bit length of the largest component.
    localparam int KW = $clog2(IN_W + 2);
    // Pipeline: 1 normalize, 1 square, 32 sqrt stages, 32 divide stages.
    localparam int NSQ = 32;
    localparam int NDV = 32;

    logic [IN_W-1:0] mx, my, mz, mm;
    logic [KW-1:0]   k;
    always_comb
    begin
        mx = vx[IN_W-1] ? IN_W'(-vx) : IN_W'(vx);
        my = vy[IN_W-1] ? IN_W'(-vy) : IN_W'(vy);
        mz = vz[IN_W-1] ? IN_W'(-vz) : IN_W'(vz);
        mm = mx | my | mz;   // same bit length as the maximum
        k = '0;
        for (int i = 0; i < IN_W; i++)
            if (mm[i]) k = KW'(i + 1);
    end

    function automatic logic signed [31:0] scale_w(logic signed [IN_W-1:0] v,
                                                   logic [KW-1:0] kk);
        logic signed [IN_W+31:0] e;
        e = (IN_W+32)'(v);
        if (kk > KW'(30)) return 32'(e >>> (kk - KW'(30)));
        return 32'(e <<< (KW'(30) - kk));
    endfunction

    logic signed [31:0] w_reg [3];
    logic               z_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0] <= scale_w(vx, k);
            w_reg[1] <= scale_w(vy, k);
            w_reg[2] <= scale_w(vz, k);
            z_reg <= (k == '0);
        end
    end

    // Stage B: sum of squares (each square below 2^60, sum below 2^62).
    logic [63:0] s_reg;
    logic signed [31:0] wb_reg [3];
    logic zb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= 64'(w_reg[0] * w_reg[0]) + 64'(w_reg[1] * w_reg[1])
                   + 64'(w_reg[2] * w_reg[2]);
            wb_reg <= w_reg;
            zb_reg <= z_reg;
        end
    end

    // Square root: one result bit per stage (restoring).
    logic [63:0] sx_reg [NSQ+1];
    logic [31:0] sr_reg [NSQ+1];
    logic signed [31:0] sw_reg [NSQ+1][3];
    logic sz_reg [NSQ+1];
    always_comb
    begin
        sx_reg[0] = s_reg;
        sr_reg[0] = '0;
        sw_reg[0] = wb_reg;
        sz_reg[0] = zb_reg;
    end
    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        logic [31:0] trial;
        logic [63:0] sq;
        always_comb
        begin
            trial = sr_reg[j] | (32'd1 << (NSQ - 1 - j));
            sq = 64'(trial) * 64'(trial);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_reg[j+1] <= (sq <= sx_reg[j]) ? trial : sr_reg[j];
                sx_reg[j+1] <= sx_reg[j];
                sw_reg[j+1] <= sw_reg[j];
                sz_reg[j+1] <= sz_reg[j];
            end
        end
    end

    // Divide: q = (|w|<<30 + L/2) / L, one quotient bit per stage, 3 lanes.
    logic [31:0] len;
    assign len = (sr_reg[NSQ] == '0) ? 32'd1 : sr_reg[NSQ];
    logic [62:0] nu_reg [NDV+1][3];
    logic [31:0] qq_reg [NDV+1][3];
    logic [31:0] dl_reg [NDV+1];
    logic        ng_reg [NDV+1][3];
    logic        dz_reg [NDV+1];
    always_comb
    begin
        dl_reg[0] = len;
        dz_reg[0] = sz_reg[NSQ];
        for (int i = 0; i < 3; i++)
        begin
            ng_reg[0][i] = sw_reg[NSQ][i][31];
            nu_reg[0][i] = (63'(sw_reg[NSQ][i][31] ? -sw_reg[NSQ][i] : sw_reg[NSQ][i])
                           << 30) + 63'(len >> 1);
            qq_reg[0][i] = '0;
        end
    end
    for (genvar j = 0; j < NDV; j++) begin : g_div
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [63:0] dsh;
            assign dsh = 64'(dl_reg[j]) << (NDV - 1 - j);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (64'(nu_reg[j][i]) >= dsh)
                    begin
                        nu_reg[j+1][i] <= 63'(64'(nu_reg[j][i]) - dsh);
                        qq_reg[j+1][i] <= qq_reg[j][i] | (32'd1 << (NDV - 1 - j));
                    end
                    else
                    begin
                        nu_reg[j+1][i] <= nu_reg[j][i];
                        qq_reg[j+1][i] <= qq_reg[j][i];
                    end
                    ng_reg[j+1][i] <= ng_reg[j][i];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dl_reg[j+1] <= dl_reg[j];
                dz_reg[j+1] <= dz_reg[j];
            end
        end
    end

    function automatic logic signed [31:0] fin(logic [31:0] q, logic n, logic z);
        if (z) return '0;
        return n ? -$signed(q) : $signed(q);
    endfunction

    assign ux = fin(qq_reg[NDV][0], ng_reg[NDV][0], dz_reg[NDV]);
    assign uy = fin(qq_reg[NDV][1], ng_reg[NDV][1], dz_reg[NDV]);
    assign uz = fin(qq_reg[NDV][2], ng_reg[NDV][2], dz_reg[NDV]);

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

>>> sv/two_contact_grasp_quality_unit.sv
// Two-contact grasp quality unit top level.
// Input channel in_valid/in_ready carries one grasp item (two contacts and
// normals, signed Q16.16) as a packed struct. Output channel out_valid/out_ready
// carries the antipodal score (Q1.30 style), force-closure flag and degenerate
// flag. Config channel cfg_valid/cfg_ready writes the friction coefficient mu
// (unsigned Q8.16, reset 0.5); write it only while the block is idle.
// Throughput: one item per cycle unless the receiver stalls. The path is the
// input register, 66 unitizer stages (normalize, square, 32 square root and
// 32 divide stages), then product, sum/round, square/min and output registers.
// The whole pipeline advances as one when the output register is free or
// being taken; a receiver stall holds every stage, so nothing is lost or
// repeated. in_ready follows that same advance condition.
// Reset clears the valid bits and restores mu together with its cone
// threshold; after each config write the threshold is recomputed by a
// bit-serial divider, so cfg_ready stays low while it runs.
module two_contact_grasp_quality_unit
    import tcgq_pkg::*;
#(
    parameter int COORD_WIDTH     = 32,
    parameter int SCORE_FRAC_BITS = 30
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  grasp_in_t         in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output grasp_out_t        out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MU_W-1:0]   cfg_data
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int UNIT_LAT = 66;
    localparam int TOT = UNIT_LAT + 5;
    // ceil(2^92 / (2^32 + 32768^2)), the threshold for the reset mu
    localparam logic [63:0] THR_RESET = 64'h0CCC_CCCC_CCCC_CCCD;

    // ---------------- cone threshold: ceil(2^92 / (2^32 + mu^2)) ----------
    logic [MU_W-1:0] mu_reg;
    logic [48:0]     den_reg;
    logic [49:0]     rem_reg;
    logic [92:0]     quo_reg;
    logic [6:0]      cnt_reg;
    logic            busy_reg, load_reg;
    logic [63:0]     thr_reg;
    logic [49:0]     r2;
    always_comb r2 = {rem_reg[48:0], (cnt_reg == 7'd0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg <= MU_W'(32768);
            load_reg <= 1'b0;
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mu_reg <= cfg_data;
            load_reg <= 1'b1;
        end
        else if (load_reg)
        begin
            den_reg <= 49'(mu_reg) * 49'(mu_reg) + (49'd1 << 32);
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
            busy_reg <= 1'b1;
            load_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd93)
            begin
                thr_reg <= 64'(quo_reg) + ((rem_reg != '0) ? 64'd1 : 64'd0);
                busy_reg <= 1'b0;
            end
            else
            begin
                if (r2 >= 50'(den_reg))
                begin
                    rem_reg <= r2 - 50'(den_reg);
                    quo_reg <= {quo_reg[91:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2;
                    quo_reg <= {quo_reg[91:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
            end
        end
    end
    assign cfg_ready = !busy_reg && !load_reg;

    // ---------------- pipeline control ----------------
    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    logic [TOT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[TOT-2:0], in_valid};
    end

    function automatic logic signed [COORD_WIDTH-1:0] cw(logic [FIELD_W-1:0] v);
        return COORD_WIDTH'(v);
    endfunction

    // Stage 0: differences and sign-extended normals.
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] n0_reg [3], n1_reg [3];
    logic deg_reg;
    logic signed [DW-1:0] dx, dy, dz;
    always_comb
    begin
        dx = DW'(cw(in_data.second_point_x)) - DW'(cw(in_data.first_point_x));
        dy = DW'(cw(in_data.second_point_y)) - DW'(cw(in_data.first_point_y));
        dz = DW'(cw(in_data.second_point_z)) - DW'(cw(in_data.first_point_z));
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= dx; d_reg[1] <= dy; d_reg[2] <= dz;
            n0_reg[0] <= DW'(cw(in_data.first_normal_x));
            n0_reg[1] <= DW'(cw(in_data.first_normal_y));
            n0_reg[2] <= DW'(cw(in_data.first_normal_z));
            n1_reg[0] <= DW'(cw(in_data.second_normal_x));
            n1_reg[1] <= DW'(cw(in_data.second_normal_y));
            n1_reg[2] <= DW'(cw(in_data.second_normal_z));
            deg_reg <= (dx == '0) && (dy == '0) && (dz == '0);
        end
    end

    logic signed [31:0] u0 [3], u1 [3], g [3];
    tcgq_unitize #(.IN_W(DW)) u_n0 (.clk, .rst_n, .en, .vx(n0_reg[0]), .vy(n0_reg[1]),
        .vz(n0_reg[2]), .ux(u0[0]), .uy(u0[1]), .uz(u0[2]));
    tcgq_unitize #(.IN_W(DW)) u_n1 (.clk, .rst_n, .en, .vx(n1_reg[0]), .vy(n1_reg[1]),
        .vz(n1_reg[2]), .ux(u1[0]), .uy(u1[1]), .uz(u1[2]));
    tcgq_unitize #(.IN_W(DW)) u_g (.clk, .rst_n, .en, .vx(d_reg[0]), .vy(d_reg[1]),
        .vz(d_reg[2]), .ux(g[0]), .uy(g[1]), .uz(g[2]));

    // Degenerate flag rides alongside the unitizers.
    logic dd_reg [UNIT_LAT];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0] <= deg_reg;
            for (int i = 1; i < UNIT_LAT; i++) dd_reg[i] <= dd_reg[i-1];
        end
    end

    // Stage P: products.
    logic signed [63:0] pa_reg [3], pb_reg [3];
    logic dp_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= 64'(u0[i]) * 64'(g[i]);
                pb_reg[i] <= 64'(u1[i]) * 64'(g[i]);
            end
            dp_reg <= dd_reg[UNIT_LAT-1];
        end
    end

    // Stage C: sums, rounding, clamp.
    function automatic logic signed [31:0] rnd(logic signed [63:0] s);
        logic signed [63:0] r;
        r = (s + 64'sd536870912) >>> 30;
        if (r > 64'sd1073741824) r = 64'sd1073741824;
        if (r < -64'sd1073741824) r = -64'sd1073741824;
        return 32'(r);
    endfunction
    logic signed [31:0] a_reg, b_reg;
    logic dc_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= rnd(-(pa_reg[0] + pa_reg[1] + pa_reg[2]));
            b_reg <= rnd(pb_reg[0] + pb_reg[1] + pb_reg[2]);
            dc_reg <= dp_reg;
        end
    end

    // Stage Q: squares and minimum.
    logic [63:0] aa_reg, bb_reg;
    logic ap_reg, bp_reg, dq_reg;
    logic signed [31:0] m_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_reg <= 64'(a_reg * a_reg);
            bb_reg <= 64'(b_reg * b_reg);
            ap_reg <= a_reg > 0;
            bp_reg <= b_reg > 0;
            m_reg <= (a_reg < b_reg) ? a_reg : b_reg;
            dq_reg <= dc_reg;
        end
    end

    // Output stage.
    localparam int SH = 30 - SCORE_FRAC_BITS;
    function automatic logic signed [31:0] red(logic signed [31:0] s);
        logic signed [32:0] t;
        if (SH == 0) return s;
        t = 33'(s) + 33'(33'sd1 <<< (SH > 0 ? SH - 1 : 0));
        return 32'(t >>> SH);
    endfunction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data.degenerate <= dq_reg;
            out_data.force_closure <= !dq_reg && ap_reg && bp_reg
                                      && aa_reg >= thr_reg && bb_reg >= thr_reg;
            out_data.antipodal_score <= dq_reg ? 32'sd0 : red(m_reg);
        end
    end
    assign out_valid = vld_reg[TOT-1];
endmodule
